// ===== design/gwc_pkg.sv =====
// Shared widths, constants and types for the GPS week time to calendar converter.
package gwc_pkg;

  typedef logic [63:0] wide_t;

  localparam int FRAC_BITS = 20;
  localparam int WEEK_BITS = 16;

  // Field widths
  localparam int WEEK_IN_W = 16;
  localparam int SOW_W     = 40;
  localparam int SEC_W     = SOW_W - FRAC_BITS;
  localparam int YEAR_W    = 12;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int MS_W      = 26;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 64;

  localparam int NSTG = 7;
  typedef logic [NSTG-1:0] stage_vec_t;

  localparam wide_t SEC_PER_MIN  = 64'd60;
  localparam wide_t SEC_PER_HOUR = 64'd3600;
  localparam wide_t SEC_PER_DAY  = 64'd86400;
  localparam wide_t SEC_PER_WEEK = 64'd604800;
  localparam wide_t GPS_DAY0     = 64'd2444245;
  localparam wide_t JD_OFS       = 64'd68569;
  localparam wide_t C_146097     = 64'd146097;
  localparam wide_t C_1461001    = 64'd1461001;
  localparam wide_t C_2447       = 64'd2447;

  localparam int DOW_W = 3;

  // Time of day
  localparam int    SOD_W  = $clog2(SEC_PER_DAY);
  localparam int    REM_W  = $clog2(SEC_PER_HOUR);
  localparam int    HR_S   = SOD_W + $clog2(SEC_PER_HOUR);
  localparam wide_t HR_M   = ((64'd1 << HR_S) + SEC_PER_HOUR - 64'd1) / SEC_PER_HOUR;
  localparam int    HR_M_W = $clog2(HR_M + 64'd1);
  localparam int    HR_P_W = SOD_W + HR_M_W;
  localparam int    MN_S   = REM_W + $clog2(SEC_PER_MIN);
  localparam wide_t MN_M   = ((64'd1 << MN_S) + SEC_PER_MIN - 64'd1) / SEC_PER_MIN;
  localparam int    MN_M_W = $clog2(MN_M + 64'd1);
  localparam int    MN_P_W = REM_W + MN_M_W;

  // Day number to date
  localparam wide_t L1_MAX = ((64'd1 << WEEK_BITS) - 64'd1) * 64'd7 + 64'd6 + GPS_DAY0 + JD_OFS;
  localparam int    L1_W   = $clog2(L1_MAX + 64'd1);
  localparam wide_t N_MAX  = (64'd4 * L1_MAX) / C_146097;
  localparam int    N_W    = $clog2(N_MAX + 64'd1);
  localparam int    N_S    = L1_W + $clog2(C_146097);
  localparam wide_t N_M    = ((64'd4 << N_S) + C_146097 - 64'd1) / C_146097;
  localparam int    N_M_W  = $clog2(N_M + 64'd1);
  localparam int    N_P_W  = L1_W + N_M_W;

  localparam int    L2_W   = 16;
  localparam int    I_W    = 7;
  localparam int    I_S    = L2_W + $clog2(C_1461001);
  localparam wide_t I_M    = ((64'd4000 << I_S) + C_1461001 - 64'd1) / C_1461001;
  localparam int    I_M_W  = $clog2(I_M + 64'd1);
  localparam int    I_P_W  = L2_W + I_M_W;

  localparam int    L3_W   = 10;
  localparam int    J_W    = 6;
  localparam int    J_S    = L3_W + $clog2(C_2447);
  localparam wide_t J_M    = ((64'd80 << J_S) + C_2447 - 64'd1) / C_2447;
  localparam int    J_M_W  = $clog2(J_M + 64'd1);
  localparam int    J_P_W  = L3_W + J_M_W;
  localparam int    JD_S   = J_W + $clog2(64'd80);
  localparam wide_t JD_M   = ((C_2447 << JD_S) + 64'd79) / 64'd80;
  localparam int    JD_M_W = $clog2(JD_M + 64'd1);
  localparam int    JD_P_W = J_W + JD_M_W;
  localparam int    YI_W   = N_W + 8;

endpackage

// ===== design/gwc_ctrl.sv =====
// Valid bits and per-stage load enables for the conversion pipeline.
module gwc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output gwc_pkg::stage_vec_t en
);
  import gwc_pkg::*;

  stage_vec_t vld;

  // A stage loads when it is empty or the stage after it loads too.
  always_comb begin
    en[NSTG-1] = ~vld[NSTG-1] | out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTG-1];

  a_drain_frees_all: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> (&en))
    else $error("taken output did not free every stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !out_ready |-> !in_ready)
    else $error("full stalled pipe took an item");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] && !out_ready |=> vld[NSTG-1])
    else $error("stalled result lost");

endmodule

// ===== design/gwc_front.sv =====
// Input stage: range check, day of week split, seconds of day and shifted day number.
module gwc_front (
  input  logic                          clk,
  input  logic                          en,
  input  logic [gwc_pkg::WEEK_IN_W-1:0] week,
  input  logic [gwc_pkg::SOW_W-1:0]     sow,
  output logic                          err,
  output logic [gwc_pkg::FRAC_BITS-1:0] frac,
  output logic [gwc_pkg::SOD_W-1:0]     sod,
  output logic [gwc_pkg::L1_W-1:0]      l1
);
  import gwc_pkg::*;

  logic [SEC_W-1:0]  secs;
  logic [DOW_W-1:0]  dow;
  logic              err_next;
  logic [SOD_W-1:0]  sod_next;
  logic [L1_W-1:0]   l1_next;

  always_comb begin
    secs = sow[SOW_W-1:FRAC_BITS];
    dow  = '0;
    // parallel threshold compares, only meaningful below one week
    for (int k = 1; k < 7; k++) begin
      if (64'(secs) >= 64'(k) * SEC_PER_DAY) begin
        dow = DOW_W'(k);
      end
    end
    err_next = 64'(secs) >= SEC_PER_WEEK;
    sod_next = SOD_W'(64'(secs) - 64'(dow) * SEC_PER_DAY);
    l1_next  = L1_W'(64'(week[WEEK_BITS-1:0]) * 64'd7 + 64'(dow) + GPS_DAY0 + JD_OFS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err  <= err_next;
      frac <= sow[FRAC_BITS-1:0];
      sod  <= sod_next;
      l1   <= l1_next;
    end
  end

endmodule

// ===== design/gwc_tod.sv =====
// Time of day pipeline: hour, minute and fixed point seconds from seconds of day.
module gwc_tod (
  input  logic                          clk,
  input  gwc_pkg::stage_vec_t           en,
  input  logic                          err,
  input  logic [gwc_pkg::FRAC_BITS-1:0] frac,
  input  logic [gwc_pkg::SOD_W-1:0]     sod,
  output logic                          range_error,
  output logic [gwc_pkg::HOUR_W-1:0]    hour,
  output logic [gwc_pkg::MIN_W-1:0]     minute,
  output logic [gwc_pkg::MS_W-1:0]      msec
);
  import gwc_pkg::*;

  logic [HR_P_W-1:0]    hr_p1;
  logic [SOD_W-1:0]     sod1;
  logic [FRAC_BITS-1:0] frac1, frac2, frac3, frac4, frac5;
  logic                 err1, err2, err3, err4, err5;
  logic [HOUR_W-1:0]    hr2, hr3, hr4, hr5;
  logic [REM_W-1:0]     rem2, rem3;
  logic [MN_P_W-1:0]    mn_p3;
  logic [MIN_W-1:0]     mn4, mn5, sc4, sc5;

  logic [HOUR_W-1:0]    hr_q;
  logic [REM_W-1:0]     rem_next;
  logic [MIN_W-1:0]     mn_q;
  logic [MIN_W-1:0]     sc_next;

  always_comb begin
    hr_q     = HOUR_W'(hr_p1 >> HR_S);
    rem_next = REM_W'(64'(sod1) - 64'(hr_q) * SEC_PER_HOUR);
    mn_q     = MIN_W'(mn_p3 >> MN_S);
    sc_next  = MIN_W'(64'(rem3) - 64'(mn_q) * SEC_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hr_p1 <= HR_P_W'(sod) * HR_M[HR_P_W-1:0];
      sod1  <= sod;
      frac1 <= frac;
      err1  <= err;
    end
    if (en[2]) begin
      hr2   <= hr_q;
      rem2  <= rem_next;
      frac2 <= frac1;
      err2  <= err1;
    end
    if (en[3]) begin
      mn_p3 <= MN_P_W'(rem2) * MN_M[MN_P_W-1:0];
      hr3   <= hr2;
      rem3  <= rem2;
      frac3 <= frac2;
      err3  <= err2;
    end
    if (en[4]) begin
      mn4   <= mn_q;
      sc4   <= sc_next;
      hr4   <= hr3;
      frac4 <= frac3;
      err4  <= err3;
    end
    if (en[5]) begin
      mn5   <= mn4;
      sc5   <= sc4;
      hr5   <= hr4;
      frac5 <= frac4;
      err5  <= err4;
    end
    if (en[6]) begin
      range_error <= err5;
      hour        <= err5 ? '0 : hr5;
      minute      <= err5 ? '0 : mn5;
      msec        <= err5 ? '0 : MS_W'({sc5, frac5});
    end
  end

endmodule

// ===== design/gwc_date.sv =====
// Date pipeline: shifted day number to Gregorian year, month and day.
module gwc_date (
  input  logic                        clk,
  input  gwc_pkg::stage_vec_t         en,
  input  logic [gwc_pkg::L1_W-1:0]    l1,
  output logic [gwc_pkg::YEAR_W-1:0]  year,
  output logic [gwc_pkg::MONTH_W-1:0] month,
  output logic [gwc_pkg::DAY_W-1:0]   day
);
  import gwc_pkg::*;

  logic [N_P_W-1:0]  n_p1;
  logic [L1_W-1:0]   l1_1;
  logic [N_W-1:0]    n2, n3, n4, n5;
  logic [L2_W-1:0]   l2_2, l2_3;
  logic [I_P_W-1:0]  i_p3;
  logic [I_W-1:0]    i4, i5;
  logic [L3_W-1:0]   l3_4, l3_5;
  logic [J_P_W-1:0]  j_p5;

  logic [N_W-1:0]    n_q;
  logic [L2_W-1:0]   l2_next;
  logic [I_W-1:0]    i_q;
  logic [L3_W-1:0]   l3_next;
  logic [J_W-1:0]    j_q;
  logic [JD_P_W-1:0] jd_p;
  logic              l4;
  logic [YI_W-1:0]   y_full;
  logic [DAY_W-1:0]  day_next;
  logic [MONTH_W-1:0] month_next;

  always_comb begin
    n_q     = N_W'(n_p1 >> N_S);
    l2_next = L2_W'(64'(l1_1) - ((64'(n_q) * C_146097 + 64'd3) >> 2));
    i_q     = I_W'(i_p3 >> I_S);
    l3_next = L3_W'(64'(l2_3) + 64'd31 - ((64'(i_q) * 64'd1461) >> 2));
    j_q     = J_W'(j_p5 >> J_S);
    jd_p    = JD_P_W'(j_q) * JD_M[JD_P_W-1:0];
    day_next = DAY_W'(64'(l3_5) - 64'(jd_p >> JD_S));
    l4      = j_q >= J_W'(11);
    month_next = MONTH_W'(j_q + J_W'(2) - (l4 ? J_W'(12) : J_W'(0)));
    y_full  = YI_W'(n5) * YI_W'(100) - YI_W'(4900) + YI_W'(i5) + YI_W'(l4);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      n_p1 <= N_P_W'(l1) * N_M[N_P_W-1:0];
      l1_1 <= l1;
    end
    if (en[2]) begin
      n2   <= n_q;
      l2_2 <= l2_next;
    end
    if (en[3]) begin
      i_p3 <= I_P_W'({1'b0, l2_2} + 17'd1) * I_M[I_P_W-1:0];
      n3   <= n2;
      l2_3 <= l2_2;
    end
    if (en[4]) begin
      i4   <= i_q;
      l3_4 <= l3_next;
      n4   <= n3;
    end
    if (en[5]) begin
      j_p5 <= J_P_W'(l3_4) * J_M[J_P_W-1:0];
      l3_5 <= l3_4;
      i5   <= i4;
      n5   <= n4;
    end
    if (en[6]) begin
      year  <= YEAR_W'(y_full);
      month <= month_next;
      day   <= day_next;
    end
  end

endmodule

// ===== design/gps_week_time_to_calendar.sv =====
// Top level: GPS week and seconds of week to Gregorian date and time of day.
//
// Input stream s_axis carries one timestamp per item: the full GPS week
// number and seconds of week as fixed point with 20 fraction bits. Output
// stream m_axis carries one result per item: year, month, day, hour, minute
// and seconds within the minute (20 fraction bits, truncated), with
// m_axis_tuser flagging seconds of week at or beyond one week; a flagged
// result has all tdata fields zero.
// Seven register stages: the input stage, then the time of day and date
// pipelines side by side behind it.
// One item per cycle sustained while m_axis is not stalled: every stage holds
// at most one multiply by a reciprocal constant, followed by a subtract.
// Each stage has its own valid bit, so while the receiver stalls the empty
// stages still fill and s_axis_tready drops only once every stage is full.
// Synchronous reset empties the pipeline; no other state is kept.
module gps_week_time_to_calendar (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // gps_week[15:0], week_seconds[55:16]
  input  logic [gwc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // cal_year[11:0], cal_month[15:12], cal_day[20:16], day_hour[25:21],
  // day_minute[31:26], minute_seconds[57:32], zero[63:58]
  output logic [gwc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // range_error[0]
  output logic                            m_axis_tuser
);
  import gwc_pkg::*;

  stage_vec_t           en;
  logic                 err0;
  logic [FRAC_BITS-1:0] frac0;
  logic [SOD_W-1:0]     sod0;
  logic [L1_W-1:0]      l1_0;
  logic                 range_error;
  logic [HOUR_W-1:0]    hour;
  logic [MIN_W-1:0]     minute;
  logic [MS_W-1:0]      msec;
  logic [YEAR_W-1:0]    year;
  logic [MONTH_W-1:0]   month;
  logic [DAY_W-1:0]     day;
  logic [YEAR_W-1:0]    year_g;
  logic [MONTH_W-1:0]   month_g;
  logic [DAY_W-1:0]     day_g;

  gwc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .en        (en)
  );

  gwc_front u_front (
    .clk  (clk),
    .en   (en[0]),
    .week (s_axis_tdata[WEEK_IN_W-1:0]),
    .sow  (s_axis_tdata[WEEK_IN_W +: SOW_W]),
    .err  (err0),
    .frac (frac0),
    .sod  (sod0),
    .l1   (l1_0)
  );

  gwc_tod u_tod (
    .clk         (clk),
    .en          (en),
    .err         (err0),
    .frac        (frac0),
    .sod         (sod0),
    .range_error (range_error),
    .hour        (hour),
    .minute      (minute),
    .msec        (msec)
  );

  gwc_date u_date (
    .clk   (clk),
    .en    (en),
    .l1    (l1_0),
    .year  (year),
    .month (month),
    .day   (day)
  );

  assign year_g  = range_error ? '0 : year;
  assign month_g = range_error ? '0 : month;
  assign day_g   = range_error ? '0 : day;

  assign m_axis_tdata = OUT_TDATA_W'({msec, minute, hour, day_g, month_g, year_g});
  assign m_axis_tuser = range_error;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("flagged item carries non-zero fields");

  a_date_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      month >= MONTH_W'(1) && month <= MONTH_W'(12) && day >= DAY_W'(1))
    else $error("date out of range");

  a_time_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      hour < HOUR_W'(24) && minute < MIN_W'(60) &&
      msec[MS_W-1:FRAC_BITS] < (MS_W - FRAC_BITS)'(60))
    else $error("time of day out of range");

endmodule

// ===== tb/sv/gps_week_time_to_calendar_test.sv =====
// Self-checking testbench for the GPS week time to calendar converter.
module gps_week_time_to_calendar_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LONG_HOLD  = 120;
  localparam int  DAY_SECS   = 86400;
  localparam int  WEEK_SECS  = 604800;
  localparam int  EPOCH_JDN  = 2444245;

  typedef struct packed {
    logic        range_error;
    logic [25:0] minute_seconds;
    logic [5:0]  day_minute;
    logic [4:0]  day_hour;
    logic [4:0]  cal_day;
    logic [3:0]  cal_month;
    logic [11:0] cal_year;
  } cal_result_t;

  class calendar_board;
    cal_result_t due_q[$];
    int unsigned failures = 0;
    int unsigned matched  = 0;
    int unsigned flagged  = 0;

    function int pending();
      return due_q.size();
    endfunction

    function cal_result_t convert_stamp(logic [15:0] week_in, logic [39:0] sow);
      longint unsigned week, secs, frac, dow, sod, hr, rem, mn, sc;
      longint jdn, l, n, i, j, d, m, y;
      cal_result_t r;
      r = '0;
      week = longint'(week_in) & ((64'd1 << gwc_pkg::WEEK_BITS) - 1);
      secs = longint'(sow) >> gwc_pkg::FRAC_BITS;
      frac = longint'(sow) & ((64'd1 << gwc_pkg::FRAC_BITS) - 1);
      if (secs >= WEEK_SECS) begin
        r.range_error = 1'b1;
        return r;
      end
      dow = secs / DAY_SECS;
      sod = secs - dow * DAY_SECS;
      hr  = sod / 3600;
      rem = sod - hr * 3600;
      mn  = rem / 60;
      sc  = rem - mn * 60;
      // integer day number to Gregorian date
      jdn = longint'(week * 7 + dow) + EPOCH_JDN;
      l = jdn + 68569;
      n = 4 * l / 146097;
      l = l - (146097 * n + 3) / 4;
      i = 4000 * (l + 1) / 1461001;
      l = l - 1461 * i / 4 + 31;
      j = 80 * l / 2447;
      d = l - 2447 * j / 80;
      l = j / 11;
      m = j + 2 - 12 * l;
      y = 100 * (n - 49) + i + l;
      r.cal_year       = y[11:0];
      r.cal_month      = m[3:0];
      r.cal_day        = d[4:0];
      r.day_hour       = hr[4:0];
      r.day_minute     = mn[5:0];
      r.minute_seconds = 26'((sc << gwc_pkg::FRAC_BITS) | frac);
      return r;
    endfunction

    function void note_input(logic [15:0] week, logic [39:0] sow);
      due_q.push_back(convert_stamp(week, sow));
    endfunction

    function void compare_field(string name, longint unsigned exp, longint unsigned got);
      if (exp != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, got);
        failures++;
      end
    endfunction

    function void check_result(logic [63:0] tdata, logic tuser);
      cal_result_t exp;
      int unsigned fail_mark;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got tdata %h tuser %b",
                 $time, tdata, tuser);
        failures++;
        return;
      end
      exp = due_q.pop_front();
      fail_mark = failures;
      compare_field("cal_year",       exp.cal_year,       tdata[11:0]);
      compare_field("cal_month",      exp.cal_month,      tdata[15:12]);
      compare_field("cal_day",        exp.cal_day,        tdata[20:16]);
      compare_field("day_hour",       exp.day_hour,       tdata[25:21]);
      compare_field("day_minute",     exp.day_minute,     tdata[31:26]);
      compare_field("minute_seconds", exp.minute_seconds, tdata[57:32]);
      compare_field("range_error",    exp.range_error,    tuser);
      if (failures == fail_mark) matched++;
      if (tuser) flagged++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;

  calendar_board board;
  bit tx_idling     = 1'b1;
  bit rx_idling     = 1'b1;
  bit long_hold_req = 1'b0;
  int hold_left     = 0;
  int stamps_sent   = 0;

  gps_week_time_to_calendar dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly no gap, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // output side: check each item taken, then pick next cycle's tready
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
      if (long_hold_req) begin
        hold_left = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_idling) hold_left = idle_len();
      end
    end
  end

  task automatic send_stamp(input logic [15:0] week, input logic [39:0] sow);
    int gap;
    gap = tx_idling ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sow, week};
    do @(posedge clk); while (!s_axis_tready);
    board.note_input(week, sow);
    stamps_sent++;
  endtask

  // timestamp on a given day number, seconds of day with fraction
  task automatic send_day(input int jdn, input int sod, input logic [19:0] frac);
    int offs;
    logic [19:0] secs;
    offs = jdn - EPOCH_JDN;
    secs = 20'((offs % 7) * DAY_SECS + sod);
    send_stamp(16'(offs / 7), {secs, frac});
  endtask

  task automatic random_stamps(input int count);
    logic [15:0] week;
    logic [19:0] secs;
    logic [19:0] frac;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      week = 16'($urandom);
      if (pick < 10) week = 16'($urandom_range(0, 2047));
      frac = 20'($urandom);
      if (pick >= 90) secs = 20'($urandom_range(WEEK_SECS, 20'hFFFFF));
      else if (pick >= 82) secs = 20'($urandom_range(0, 6) * DAY_SECS + DAY_SECS - 1);
      else secs = 20'($urandom_range(0, WEEK_SECS - 1));
      send_stamp(week, {secs, frac});
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // corners of the fields and the range check
    send_stamp(16'h0000, 40'h0);
    send_stamp(16'hFFFF, {20'(WEEK_SECS - 1), 20'hFFFFF});
    send_stamp(16'h0000, {20'(WEEK_SECS), 20'h0});
    send_stamp(16'hFFFF, 40'hFF_FFFF_FFFF);
    send_stamp(16'h5555, 40'hAA_AAAA_AAAA);
    send_stamp(16'hAAAA, 40'h55_5555_5555);
    send_stamp(16'd1, {20'(DAY_SECS - 1), 20'hFFFFF});
    send_stamp(16'd1, {20'(DAY_SECS), 20'h0});
    send_stamp(16'd1023, {20'd3599, 20'hFFFFF});
    send_stamp(16'd1024, 40'h0);
    send_stamp(16'd2048, {20'd59, 20'h80000});
    // year ends, leap days, the non-leap century
    send_day(2451544, DAY_SECS - 1, 20'hFFFFF);
    send_day(2451545, 0, 20'h0);
    send_day(2451603, 43200, 20'h12345);
    send_day(2451604, 3661, 20'h00001);
    send_day(2451605, 0, 20'h0);
    send_day(2488128, DAY_SECS - 1, 20'hFFFFF);
    send_day(2488129, 0, 20'h0);
    send_day(2460310, 82800, 20'h7FFFF);
    send_day(2460370, 60, 20'h0);

    random_stamps(250);

    // back to back on both sides
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    random_stamps(150);

    // long output stall while input keeps coming, so the pipe fills
    long_hold_req = 1'b1;
    random_stamps(40);

    tx_idling = 1'b1;
    rx_idling = 1'b1;
    wait_drained();
    random_stamps(310);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("%0d timestamps sent, %0d results matched, %0d flagged out of range;",
             stamps_sent, board.matched, board.flagged);
    $display("included back-to-back traffic and a %0d-cycle output stall", LONG_HOLD);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("simulation failed");
    $finish;
  end

endmodule
